/* src/cap_pkg.sv */
package cap_pkg;

  localparam int unsigned FracBits   = 16;
  localparam int unsigned MaxSamples = 64;
  localparam int unsigned CntW       = $clog2(MaxSamples + 1);
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgW       = 31;
  localparam int unsigned AluIterW   = 7;

  localparam logic [CfgIdxW-1:0] CfgFillUntil = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgClamp     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFillStep  = 2'd2;

  typedef enum logic {
    CapOpDiv  = 1'b0,
    CapOpSqrt = 1'b1
  } cap_op_e;

  typedef struct packed {
    logic    start;
    cap_op_e op;
  } cap_alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cap_alu_rsp_t;

endpackage

/* src/const_accel_path_sampler_top.sv */
// Constant-acceleration path sampler. Each input beat (start state, segment length,
// acceleration, step length in Q16.16, the lengths unsigned and the rest signed) produces
// a run of 1 to 64 output beats: the start state, one state per step, and zero-speed
// padding states for runs that stop. The block takes one input beat at a time.
// Arithmetic runs on one shared iterative unit that retires one quotient bit or one root
// bit per cycle: a run with negative acceleration first divides for its stopping distance,
// and each moving sample takes a square root, a divide (skipped when start speed and
// acceleration are both zero), multiplies, setup and hand-off; padding uses no divide.
module const_accel_path_sampler_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [31:0]                start_position_i,
  input  logic signed [31:0]                start_speed_i,
  input  logic signed [31:0]                start_time_i,
  input  logic [30:0]                       segment_length_i,
  input  logic signed [31:0]                acceleration_i,
  input  logic [30:0]                       step_length_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [31:0]                position_o,
  output logic signed [31:0]                speed_o,
  output logic signed [31:0]                sample_time_o,
  output logic                              last_sample_o,
  output logic                              truncated_o,
  input  logic                              cfg_we_i,
  input  logic [cap_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [cap_pkg::CfgW-1:0]          cfg_data_i
);

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SSl0  = 4'd1;
  localparam logic [3:0] SSl1  = 4'd2;
  localparam logic [3:0] SSl2  = 4'd3;
  localparam logic [3:0] SGen  = 4'd4;
  localparam logic [3:0] SEmit = 4'd5;
  localparam logic [3:0] SChk  = 4'd6;
  localparam logic [3:0] SMsq  = 4'd7;
  localparam logic [3:0] SMlin = 4'd8;
  localparam logic [3:0] SMrad = 4'd9;
  localparam logic [3:0] SMsqw = 4'd10;
  localparam logic [3:0] SMdv  = 4'd11;
  localparam logic [3:0] SMdvw = 4'd12;
  localparam logic [3:0] SMout = 4'd13;
  localparam logic [3:0] SPad  = 4'd14;
  localparam logic [3:0] SFin  = 4'd15;

  logic [3:0] state_q, state_d;

  logic [30:0] fill_until_q, clamp_q, fill_step_q;

  logic signed [31:0] v0_q, a_q;
  logic [30:0] seg_q, ds_q;
  logic [30:0] target_q, covered_q, step_q;
  logic stop_q, last_q, cut_q, pad_q;
  logic [cap_pkg::CntW-1:0] cnt_q;
  logic [63:0] prod_q, sq_q;
  logic [31:0] nv_q;
  logic signed [31:0] dt_q;

  logic signed [31:0] nxt_pos_q, nxt_spd_q, nxt_t_q;
  logic pend_valid_q;
  logic signed [31:0] pend_pos_q, pend_spd_q, pend_t_q;

  logic out_valid_q, out_last_q, out_trunc_q;
  logic signed [31:0] out_pos_q, out_spd_q, out_t_q;

  cap_pkg::cap_alu_req_t alu_req;
  cap_pkg::cap_alu_rsp_t alu_rsp;
  logic [63:0] alu_opnd, alu_res;
  logic [32:0] alu_dvsr;

  logic [31:0] amag, vmag, pm, mul_a, mul_b;
  logic [63:0] mul_p, lin, rad;
  logic [30:0] remain;
  logic in_acc, out_free, out_load, out_load_last;
  logic signed [32:0] diff;
  logic [32:0] diff_mag;
  logic dt_neg;
  logic [31:0] dt_sat, root_sat;
  logic signed [32:0] pos_sum, t_sum, pad_t;

  function automatic logic [31:0] sat33(input logic signed [32:0] x);
    logic [31:0] r;
    if (x[32] != x[31]) begin
      r = x[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  assign in_acc   = in_valid_i && (state_q == SIdle);
  assign out_free = !out_valid_q || !out_stall_i;

  assign amag = a_q[31] ? 32'(-a_q) : 32'(a_q);
  assign vmag = v0_q[31] ? 32'(-v0_q) : 32'(v0_q);
  assign pm   = pend_spd_q[31] ? 32'(-pend_spd_q) : 32'(pend_spd_q);
  assign remain = target_q - covered_q;

  always_comb begin
    unique case (state_q)
      SSl0: begin
        mul_a = vmag;
        mul_b = vmag;
      end
      SMlin: begin
        mul_a = amag;
        mul_b = {1'b0, step_q};
      end
      default: begin
        mul_a = pm;
        mul_b = pm;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign lin = {prod_q[62:0], 1'b0};
  assign rad = !a_q[31] ? (sq_q + lin) : ((sq_q > lin) ? (sq_q - lin) : 64'd0);

  assign diff     = $signed({1'b0, nv_q}) - 33'(pend_spd_q);
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign dt_neg   = (a_q != 0) ? (diff[32] ^ a_q[31]) : v0_q[31];

  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = cap_pkg::CapOpDiv;
    alu_opnd      = prod_q;
    alu_dvsr      = {amag, 1'b0};
    unique case (state_q)
      SSl1: alu_req.start = 1'b1;
      SMrad: begin
        alu_req.start = 1'b1;
        alu_req.op    = cap_pkg::CapOpSqrt;
        alu_opnd      = rad;
      end
      SMdv: begin
        alu_req.start = (a_q != 0) || (v0_q != 0);
        if (a_q != 0) begin
          alu_opnd = 64'(diff_mag) << cap_pkg::FracBits;
          alu_dvsr = {1'b0, amag};
        end else begin
          alu_opnd = 64'(step_q) << cap_pkg::FracBits;
          alu_dvsr = {1'b0, vmag};
        end
      end
      default: ;
    endcase
  end

  cap_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .opnd_i (alu_opnd),
    .dvsr_i (alu_dvsr),
    .rsp_o  (alu_rsp),
    .res_o  (alu_res)
  );

  always_comb begin
    if (!dt_neg) begin
      dt_sat = (|alu_res[63:31]) ? 32'h7FFF_FFFF : alu_res[31:0];
    end else if ((|alu_res[63:32]) || (alu_res[31] && (|alu_res[30:0]))) begin
      dt_sat = 32'h8000_0000;
    end else begin
      dt_sat = 32'(-alu_res[31:0]);
    end
    root_sat = (|alu_res[63:31]) ? 32'h7FFF_FFFF : alu_res[31:0];
  end

  assign pos_sum = 33'(pend_pos_q) + $signed({2'b00, step_q});
  assign t_sum   = 33'(pend_t_q) + 33'(dt_q);
  assign pad_t   = 33'(pend_t_q) + $signed({2'b00, fill_step_q});

  assign out_load      = (state_q == SEmit) && pend_valid_q && out_free;
  assign out_load_last = (state_q == SFin) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (in_valid_i) begin
        state_d = acceleration_i[31] ? SSl0 : SGen;
      end
      SSl0: state_d = SSl1;
      SSl1: state_d = SSl2;
      SSl2: if (alu_rsp.done) begin
        state_d = SGen;
      end
      SGen: state_d = (cnt_q == cap_pkg::CntW'(cap_pkg::MaxSamples)) ? SFin : SEmit;
      SEmit: if (!pend_valid_q || out_free) begin
        state_d = pad_q ? SPad : SChk;
      end
      SChk: begin
        priority if (!last_q && (covered_q < target_q)) state_d = SMsq;
        else if (stop_q) state_d = SPad;
        else state_d = SFin;
      end
      SMsq:  state_d = SMlin;
      SMlin: state_d = SMrad;
      SMrad: state_d = SMsqw;
      SMsqw: if (alu_rsp.done) begin
        state_d = SMdv;
      end
      SMdv: state_d = ((a_q != 0) || (v0_q != 0)) ? SMdvw : SMout;
      SMdvw: if (alu_rsp.done) begin
        state_d = SMout;
      end
      SMout: state_d = SGen;
      SPad: begin
        if ((pend_t_q < $signed({1'b0, fill_until_q})) &&
            (pend_t_q < $signed({1'b0, clamp_q}))) begin
          state_d = SGen;
        end else begin
          state_d = SFin;
        end
      end
      SFin: if (out_free) begin
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      fill_until_q <= 31'd524288;
      clamp_q      <= 31'd524288;
      fill_step_q  <= 31'd6554;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
      cut_q        <= 1'b0;
      pad_q        <= 1'b0;
      stop_q       <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cap_pkg::CfgFillUntil: fill_until_q <= cfg_data_i;
          cap_pkg::CfgClamp:     clamp_q      <= cfg_data_i;
          cap_pkg::CfgFillStep:  fill_step_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load || out_load_last) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        cnt_q        <= '0;
        cut_q        <= 1'b0;
        pad_q        <= 1'b0;
        last_q       <= 1'b0;
        pend_valid_q <= 1'b0;
        stop_q       <= (acceleration_i == 0) && (start_speed_i == 0);
      end
      if ((state_q == SSl2) && alu_rsp.done) begin
        stop_q <= (alu_res < 64'(seg_q)) || (v0_q == 0);
      end
      if ((state_q == SGen) && (cnt_q == cap_pkg::CntW'(cap_pkg::MaxSamples))) begin
        cut_q <= 1'b1;
      end
      if ((state_q == SEmit) && (!pend_valid_q || out_free)) begin
        pend_valid_q <= 1'b1;
        cnt_q        <= cnt_q + 1'b1;
      end
      if ((state_q == SChk) && !(!last_q && (covered_q < target_q)) && stop_q) begin
        pad_q <= 1'b1;
      end
      if (state_q == SMsq) begin
        last_q <= (ds_q > remain);
      end
      if (out_load_last) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      v0_q      <= start_speed_i;
      a_q       <= acceleration_i;
      seg_q     <= segment_length_i;
      ds_q      <= step_length_i;
      covered_q <= '0;
      step_q    <= '0;
      nxt_pos_q <= start_position_i;
      nxt_spd_q <= start_speed_i;
      nxt_t_q   <= start_time_i;
      target_q  <= ((acceleration_i == 0) && (start_speed_i == 0)) ? 31'd0 : segment_length_i;
    end
    if ((state_q == SSl2) && alu_rsp.done) begin
      if (v0_q == 0) begin
        target_q <= '0;
      end else if (alu_res < 64'(seg_q)) begin
        target_q <= alu_res[30:0];
      end
    end
    if ((state_q == SSl0) || (state_q == SMsq) || (state_q == SMlin)) begin
      prod_q <= mul_p;
    end
    if (state_q == SMsq) begin
      step_q <= (ds_q > remain) ? remain : ds_q;
    end
    if (state_q == SMlin) begin
      sq_q <= prod_q;
    end
    if ((state_q == SMsqw) && alu_rsp.done) begin
      nv_q <= root_sat;
    end
    if (state_q == SMdv) begin
      dt_q <= '0;
    end
    if ((state_q == SMdvw) && alu_rsp.done) begin
      dt_q <= dt_sat;
    end
    if (state_q == SMout) begin
      nxt_pos_q <= sat33(pos_sum);
      nxt_spd_q <= nv_q;
      nxt_t_q   <= sat33(t_sum);
    end
    if (state_q == SPad) begin
      nxt_pos_q <= pend_pos_q;
      nxt_spd_q <= '0;
      nxt_t_q   <= (pad_t > $signed({2'b00, clamp_q})) ? {1'b0, clamp_q} : pad_t[31:0];
    end
    if ((state_q == SEmit) && (!pend_valid_q || out_free)) begin
      pend_pos_q <= nxt_pos_q;
      pend_spd_q <= nxt_spd_q;
      pend_t_q   <= nxt_t_q;
      covered_q  <= covered_q + step_q;
    end
    if (out_load || out_load_last) begin
      out_pos_q   <= pend_pos_q;
      out_spd_q   <= pend_spd_q;
      out_t_q     <= pend_t_q;
      out_last_q  <= out_load_last;
      out_trunc_q <= out_load_last && cut_q;
    end
  end

  assign in_stall_o    = (state_q != SIdle);
  assign out_valid_o   = out_valid_q;
  assign position_o    = out_pos_q;
  assign speed_o       = out_spd_q;
  assign sample_time_o = out_t_q;
  assign last_sample_o = out_last_q;
  assign truncated_o   = out_trunc_q;

`ifndef SYNTHESIS
  a_trunc_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && truncated_o |-> last_sample_o)
    else $error("truncated beat is not the last beat");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cap_pkg::CntW'(cap_pkg::MaxSamples))
    else $error("sample count beyond limit");

  a_alu_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q == SSl2 || state_q == SMsqw || state_q == SMdvw))
    else $error("arithmetic unit finished outside a wait state");

  a_fin_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SFin |-> pend_valid_q)
    else $error("run ends without a pending sample");
`endif

endmodule

/* src/cap_alu.sv */
module cap_alu (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cap_pkg::cap_alu_req_t req_i,
  input  logic [63:0]           opnd_i,
  input  logic [32:0]           dvsr_i,
  output cap_pkg::cap_alu_rsp_t rsp_o,
  output logic [63:0]           res_o
);

  logic [63:0] x_q;
  logic [35:0] rem_q;
  logic [63:0] q_q;
  logic [32:0] d_q;
  logic [cap_pkg::AluIterW-1:0] cnt_q;
  cap_pkg::cap_op_e op_q;
  logic busy_q;
  logic done_q;

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;
  logic [cap_pkg::AluIterW-1:0] last_iter;

  always_comb begin
    if (op_q == cap_pkg::CapOpSqrt) begin
      rem_sh    = {rem_q[33:0], x_q[63:62]};
      trial     = {1'b0, q_q[32:0], 2'b01};
      last_iter = cap_pkg::AluIterW'(31);
    end else begin
      rem_sh    = {rem_q[34:0], x_q[63]};
      trial     = {3'b000, d_q};
      last_iter = cap_pkg::AluIterW'(63);
    end
    ge = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == last_iter) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= opnd_i;
      d_q   <= dvsr_i;
      op_q  <= req_i.op;
      rem_q <= '0;
      q_q   <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? (rem_sh - trial) : rem_sh;
      q_q   <= {q_q[62:0], ge};
      x_q   <= (op_q == cap_pkg::CapOpSqrt) ? {x_q[61:0], 2'b00} : {x_q[62:0], 1'b0};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign res_o      = q_q;

endmodule

/* bench/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] spd;
    logic signed [31:0] tim;
    logic               last;
    logic               trunc;
  } sample_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] start_position_i = '0;
  logic signed [31:0] start_speed_i = '0;
  logic signed [31:0] start_time_i = '0;
  logic [30:0] segment_length_i = '0;
  logic signed [31:0] acceleration_i = '0;
  logic [30:0] step_length_i = 31'd1;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] position_o, speed_o, sample_time_o;
  logic last_sample_o, truncated_o;
  logic cfg_we_i = 1'b0;
  logic [cap_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [cap_pkg::CfgW-1:0] cfg_data_i = '0;

  const_accel_path_sampler_top i_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [30:0] fill_until_q, clamp_q, fill_step_q;
  sample_t expected_samples[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_rx = 1'b0;
  bit flood = 1'b0;

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned magn(longint x);
    return x < 0 ? longint'(-x) : x;
  endfunction

  task automatic predict_run(longint s0, longint v0, longint t0, longint unsigned seg,
                             longint a, longint unsigned ds);
    sample_t run[$];
    longint unsigned target, covered, rem, stp, sq, lin, rad, root, stop_len;
    longint ps, pv, pt, nv, dt, nt;
    bit stopped, cut, last;
    cut = 1'b0;
    stopped = 1'b0;
    target = seg;
    covered = 0;
    if (a < 0) begin
      stop_len = (magn(v0) * magn(v0)) / (2 * magn(a));
      if (stop_len < seg) begin
        target = stop_len;
        stopped = 1'b1;
      end
    end
    if (a <= 0 && v0 == 0) begin
      target = 0;
      stopped = 1'b1;
    end
    ps = s0; pv = v0; pt = t0;
    run.insert(run.size(), '{32'(ps), 32'(pv), 32'(pt), 1'b0, 1'b0});
    while (covered < target) begin
      rem = target - covered;
      stp = ds;
      last = 1'b0;
      if (stp > rem) begin
        stp = rem;
        last = 1'b1;
      end
      sq = magn(pv) * magn(pv);
      lin = 2 * magn(a) * stp;
      if (a >= 0) rad = sq + lin;
      else rad = (sq > lin) ? sq - lin : 0;
      root = int_sqrt(rad);
      nv = root > 64'd2147483647 ? 64'sd2147483647 : longint'(root);
      if (a != 0) dt = ((nv - pv) * 65536) / a;
      else if (v0 != 0) dt = (longint'(stp) * 65536) / v0;
      else dt = 0;
      dt = sat32(dt);
      if (run.size() >= cap_pkg::MaxSamples) begin
        cut = 1'b1;
        break;
      end
      ps = sat32(ps + longint'(stp));
      pv = nv;
      pt = sat32(pt + dt);
      run.insert(run.size(), '{32'(ps), 32'(pv), 32'(pt), 1'b0, 1'b0});
      covered += stp;
      if (last) break;
    end
    if (stopped && !cut) begin
      while (pt < longint'(fill_until_q) && pt < longint'(clamp_q)) begin
        nt = pt + longint'(fill_step_q);
        if (nt > longint'(clamp_q)) nt = longint'(clamp_q);
        if (run.size() >= cap_pkg::MaxSamples) begin
          cut = 1'b1;
          break;
        end
        pv = 0;
        pt = sat32(nt);
        run.insert(run.size(), '{32'(ps), 32'(pv), 32'(pt), 1'b0, 1'b0});
      end
    end
    run[run.size()-1].last = 1'b1;
    run[run.size()-1].trunc = cut;
    foreach (run[i]) expected_samples.insert(expected_samples.size(), run[i]);
  endtask

  task automatic send_item(logic [31:0] s, logic [31:0] v, logic [31:0] t, logic [30:0] seg,
                           logic [31:0] a, logic [30:0] ds);
    int gap;
    gap = flood ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(posedge clk_i);
    predict_run($signed(s), $signed(v), $signed(t), seg, $signed(a), ds);
    start_position_i <= s;
    start_speed_i <= v;
    start_time_i <= t;
    segment_length_i <= seg;
    acceleration_i <= a;
    step_length_i <= ds;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [cap_pkg::CfgIdxW-1:0] idx, logic [30:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      cap_pkg::CfgFillUntil: fill_until_q = val;
      cap_pkg::CfgClamp:     clamp_q = val;
      cap_pkg::CfgFillStep:  fill_step_q = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_cfg(logic [30:0] fu, logic [30:0] cl, logic [30:0] fs);
    drain();
    write_cfg(cap_pkg::CfgFillUntil, fu);
    write_cfg(cap_pkg::CfgClamp, cl);
    write_cfg(cap_pkg::CfgFillStep, fs);
  endtask

  task automatic test_directed();
    send_item(32'h0001_0000, 32'h0002_0000, 0, 31'h0004_0000, 32'h0001_0000, 31'h0001_0000);
    send_item(0, 32'h0004_0000, 0, 31'h0010_0000, 32'hFFFE_0000, 31'h0000_8000);
    send_item(0, 0, 0, 31'h0001_0000, 0, 31'h0000_4000);
    send_item(0, 0, 32'h0001_0000, 31'h0001_0000, 32'hFFFF_0000, 31'h0000_4000);
    send_item(0, 32'h0001_0000, 0, 31'h0001_0000, 0, 31'h0000_4000);
    send_item(0, 32'hFFFF_0000, 0, 31'h0001_0000, 0, 31'h0000_4000);
    send_item(0, 0, 32'h0010_0000, 31'h0, 0, 31'h1);
    send_item(32'h7FFF_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
              32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
              32'h8000_0000, 31'h1);
    send_item(32'h7FFF_FFF0, 32'h0001_0000, 0, 31'h0010_0000, 32'h0001_0000, 31'h0001_0000);
    send_item(0, 32'h0001_0000, 0, 31'h0001_0000, 32'hFFFF_FFFF, 31'h1);
    send_item(0, 32'h0000_1000, 0, 31'h0000_0100, 32'h0000_0001, 31'h0000_0010);
    send_item(0, 32'h0003_0000, 32'hFFF0_0000, 31'h0008_0000, 32'hFFFD_0000, 31'h0001_0000);
  endtask

  task automatic test_cfg_extremes();
    set_cfg(31'h0, 31'h0, 31'h1);
    send_item(0, 0, 0, 31'h1000, 0, 31'h100);
    send_item(0, 32'h0001_0000, 0, 31'h0001_0000, 32'hFFFF_0000, 31'h4000);
    set_cfg(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_item(0, 0, 32'h7FFF_0000, 0, 0, 31'h1);
    send_item(0, 0, 32'hFFFF_0000, 0, 0, 31'h1);
    set_cfg(31'h0008_0000, 31'h0004_0000, 31'h1);
    send_item(0, 0, 0, 0, 0, 31'h1);
    set_cfg(31'h0004_0000, 31'h0008_0000, 31'h0000_4000);
    send_item(0, 0, 0, 0, 0, 31'h1);
    drain();
    write_cfg(2'd3, 31'h1234);
    send_item(0, 0, 0, 0, 0, 31'h1);
  endtask

  task automatic random_item();
    logic [31:0] s, v, t, a;
    logic [30:0] seg, ds;
    s = $urandom;
    t = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0008_0000);
    v = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0008_0000);
    if ($urandom_range(0, 1)) v = -v;
    if ($urandom_range(0, 5) == 0) v = 0;
    a = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0004_0000);
    if ($urandom_range(0, 1)) a = -a;
    if ($urandom_range(0, 5) == 0) a = 0;
    seg = $urandom_range(0, 5) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h0008_0000));
    ds = $urandom_range(0, 5) == 0 ? 31'($urandom) : 31'($urandom_range(1, 32'h0004_0000));
    if (ds == 0) ds = 1;
    send_item(s, v, t, seg, a, ds);
  endtask

  task automatic test_random();
    for (int i = 0; i < 230; i++) begin
      if (i == 80) set_cfg(31'($urandom_range(0, 32'h0010_0000)),
                           31'($urandom_range(0, 32'h0010_0000)),
                           31'($urandom_range(1, 32'h0002_0000)));
      if (i == 160) set_cfg(31'h0008_0000, 31'h0008_0000, 31'd6554);
      random_item();
    end
  endtask

  task automatic test_backpressure();
    drain();
    flood = 1'b1;
    hold_rx = 1'b1;
    for (int i = 0; i < 15; i++) random_item();
    flood = 1'b0;
    drain();
  endtask

  always @(posedge clk_i) begin
    int wait_n;
    if (hold_rx) begin
      out_stall_i <= 1'b1;
      repeat (3000) @(posedge clk_i);
      hold_rx = 1'b0;
      out_stall_i <= 1'b0;
    end else if (out_valid_o && !out_stall_i) begin
      wait_n = $urandom_range(0, 18);
      if ($urandom_range(0, 3) == 0) wait_n = 0;
      if (wait_n != 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    sample_t exp_s;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_samples.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat pos=%h spd=%h t=%h", position_o,
                                   speed_o, sample_time_o);
      end else begin
        exp_s = expected_samples.pop_front();
        if ({position_o, speed_o, sample_time_o, last_sample_o, truncated_o} !== exp_s) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp pos=%h spd=%h t=%h l=%b c=%b got %h %h %h %b %b",
                     exp_s.pos, exp_s.spd, exp_s.tim, exp_s.last, exp_s.trunc,
                     position_o, speed_o, sample_time_o, last_sample_o, truncated_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 60000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    fill_until_q = 31'd524288;
    clamp_q = 31'd524288;
    fill_step_q = 31'd6554;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_cfg_extremes();
    test_random();
    test_backpressure();
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
